/* src/fld_pkg.sv */
// ----------------------------------------------------------------------------
// fld_pkg
// Shared types and constants for the weighted two-store dispatcher.
// ----------------------------------------------------------------------------
package fld_pkg;

  localparam int VAL_W = 16;
  localparam int CFG_W = 4;
  localparam int ACT_W = 2;
  localparam int STS_W = 2;

  localparam logic [CFG_W-1:0] WAITING_PER_ROUND_RST = 4'd3;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD_WAIT = 2'd0,
    ACT_ADD_MISS = 2'd1,
    ACT_SERVE    = 2'd2,
    ACT_IGNORE   = 2'd3
  } action_t;

  typedef enum logic [STS_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    FROM_WAITING = 1'b0,
    FROM_MISSED  = 1'b1
  } source_t;

  // What one cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_PREV,
    CELL_TAKE_NEXT
  } cell_op_t;

  // What a whole chain does in a cycle.
  typedef enum logic [1:0] {
    CH_IDLE,
    CH_APPEND,
    CH_PUSH_FRONT,
    CH_POP
  } chain_cmd_t;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] served_value;
    source_t          served_from;
  } result_t;

endpackage

/* src/fld_req_if.sv */
// ----------------------------------------------------------------------------
// fld_req_if
// Request channel: one beat carries an action and an entry value.
// ----------------------------------------------------------------------------
interface fld_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] entry_value;

  modport source (output valid, output action, output entry_value, input ready);
  modport sink   (input valid, input action, input entry_value, output ready);
endinterface

/* src/fld_rsp_if.sv */
// ----------------------------------------------------------------------------
// fld_rsp_if
// Response channel: one beat carries the status and any served entry.
// ----------------------------------------------------------------------------
interface fld_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] served_value;
  logic        served_from;

  modport source (output valid, output status, output served_value,
                  output served_from, input ready);
  modport sink   (input valid, input status, input served_value,
                  input served_from, output ready);
endinterface

/* src/fld_cell.sv */
// ----------------------------------------------------------------------------
// fld_cell
// One storage cell of a chain: holds a value, loads a new one, or takes
// the value of either neighbor.
// ----------------------------------------------------------------------------
module fld_cell import fld_pkg::*; (
  input  logic             clk,
  input  cell_op_t         op,
  input  logic [VAL_W-1:0] din,
  input  logic [VAL_W-1:0] prev,
  input  logic [VAL_W-1:0] next,
  output logic [VAL_W-1:0] q
);

  logic [VAL_W-1:0] value;

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_HOLD:      value <= value;
      CELL_LOAD:      value <= din;
      CELL_TAKE_PREV: value <= prev;
      CELL_TAKE_NEXT: value <= next;
      default:        value <= value;
    endcase
  end

  assign q = value;

endmodule

/* src/fld_chain.sv */
// ----------------------------------------------------------------------------
// fld_chain
// A row of cells with cell 0 at the front. Serves as a queue (append at the
// fill level, pop from the front) or as a stack (push and pop at the front).
// ----------------------------------------------------------------------------
module fld_chain import fld_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  chain_cmd_t       cmd,
  input  logic [CNT_W-1:0] fill,
  input  logic [VAL_W-1:0] din,
  output logic [VAL_W-1:0] front
);

  logic [VAL_W-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_op_t         op;
    logic [VAL_W-1:0] prev;
    logic [VAL_W-1:0] next;

    always_comb begin
      unique case (cmd)
        CH_APPEND:     op = (fill == CNT_W'(i)) ? CELL_LOAD : CELL_HOLD;
        CH_PUSH_FRONT: op = CELL_TAKE_PREV;
        CH_POP:        op = CELL_TAKE_NEXT;
        default:       op = CELL_HOLD;
      endcase
    end

    if (i == 0) begin : g_first
      assign prev = din;
    end else begin : g_mid_prev
      assign prev = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next = '0;
    end else begin : g_mid_next
      assign next = q[i+1];
    end

    fld_cell u_cell (
      .clk  (clk),
      .op   (op),
      .din  (din),
      .prev (prev),
      .next (next),
      .q    (q[i])
    );
  end

  assign front = q[0];

endmodule

/* src/fifo_lifo_weighted_dispatcher.sv */
// ----------------------------------------------------------------------------
// fifo_lifo_weighted_dispatcher
// Weighted dispatcher over a waiting queue and a missed stack.
// ----------------------------------------------------------------------------
// Takes one request beat per clock and answers each with exactly one response
// beat, registered. Every action touches only the front of a chain of cells
// (or, for a queue append, the cell at the fill level), so no action makes the
// request side wait. A two-slot response buffer lets one more request in while
// a response is held by the sink; the request side stalls only when both slots
// are occupied or in reset. Serving runs in rounds of up to waiting_per_round
// queue entries followed by one stack entry; pushes into a full store are
// dropped with a full status. Stores hold no reset values and need no clearing
// pass.
// ----------------------------------------------------------------------------
module fifo_lifo_weighted_dispatcher import fld_pkg::*; #(
  parameter int WAIT_DEPTH = 64,
  parameter int MISS_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  fld_req_if.sink          req,
  fld_rsp_if.source        rsp
);

  localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);
  localparam int MCNT_W = $clog2(MISS_DEPTH + 1);

  logic [CFG_W-1:0]  waiting_per_round;
  logic [WCNT_W-1:0] waiting_count, waiting_count_next;
  logic [MCNT_W-1:0] missed_top, missed_top_next;
  logic [CFG_W-1:0]  round_served, round_served_next;

  chain_cmd_t       wait_cmd, miss_cmd;
  logic [VAL_W-1:0] wait_front, miss_front;
  result_t          res;

  result_t out_data, skid_data;
  logic    out_valid, skid_valid;
  logic    accept, take;
  action_t act;

  assign req.ready = !rst && !skid_valid;
  assign accept    = req.valid && req.ready;
  assign take      = out_valid && rsp.ready;
  assign act       = action_t'(req.action);

  fld_chain #(.DEPTH(WAIT_DEPTH), .CNT_W(WCNT_W)) u_waiting (
    .clk   (clk),
    .cmd   (wait_cmd),
    .fill  (waiting_count),
    .din   (req.entry_value),
    .front (wait_front)
  );

  fld_chain #(.DEPTH(MISS_DEPTH), .CNT_W(MCNT_W)) u_missed (
    .clk   (clk),
    .cmd   (miss_cmd),
    .fill  (missed_top),
    .din   (req.entry_value),
    .front (miss_front)
  );

  always_comb begin
    wait_cmd           = CH_IDLE;
    miss_cmd           = CH_IDLE;
    waiting_count_next = waiting_count;
    missed_top_next    = missed_top;
    round_served_next  = round_served;
    res.status         = ST_ACCEPTED;
    res.served_value   = '0;
    res.served_from    = FROM_WAITING;
    unique case (act)
      ACT_ADD_WAIT: begin
        if (waiting_count == WCNT_W'(WAIT_DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          wait_cmd           = CH_APPEND;
          waiting_count_next = waiting_count + WCNT_W'(1);
        end
      end
      ACT_ADD_MISS: begin
        if (missed_top == MCNT_W'(MISS_DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          miss_cmd        = CH_PUSH_FRONT;
          missed_top_next = missed_top + MCNT_W'(1);
        end
      end
      ACT_SERVE: begin
        priority if (waiting_count == '0 && missed_top == '0) begin
          res.status        = ST_EMPTY;
          round_served_next = '0;
        end else if (waiting_count != '0 && round_served < waiting_per_round) begin
          res.status         = ST_SERVED;
          res.served_value   = wait_front;
          wait_cmd           = CH_POP;
          waiting_count_next = waiting_count - WCNT_W'(1);
          round_served_next  = round_served + CFG_W'(1);
        end else if (missed_top != '0) begin
          res.status        = ST_SERVED;
          res.served_value  = miss_front;
          res.served_from   = FROM_MISSED;
          miss_cmd          = CH_POP;
          missed_top_next   = missed_top - MCNT_W'(1);
          round_served_next = '0;
        end else begin
          // Quota used up with nothing missed: this entry opens a new round.
          res.status         = ST_SERVED;
          res.served_value   = wait_front;
          wait_cmd           = CH_POP;
          waiting_count_next = waiting_count - WCNT_W'(1);
          round_served_next  = CFG_W'(1);
        end
      end
      ACT_IGNORE: begin
      end
      default: begin
      end
    endcase
    if (!accept) begin
      wait_cmd           = CH_IDLE;
      miss_cmd           = CH_IDLE;
      waiting_count_next = waiting_count;
      missed_top_next    = missed_top;
      round_served_next  = round_served;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting_per_round <= WAITING_PER_ROUND_RST;
      waiting_count     <= '0;
      missed_top        <= '0;
      round_served      <= '0;
    end else begin
      if (cfg_we) begin
        waiting_per_round <= cfg_wdata;
      end
      waiting_count <= waiting_count_next;
      missed_top    <= missed_top_next;
      round_served  <= round_served_next;
    end
  end

  // Response buffer: the output register plus one skid slot behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (accept) begin
      if (!out_valid || take) begin
        out_data <= res;
      end else begin
        skid_data <= res;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_data.status;
  assign rsp.served_value = out_data.served_value;
  assign rsp.served_from  = out_data.served_from;

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted two-store dispatcher.
// ----------------------------------------------------------------------------
// A directed opening walks the basic service order, empty serves and ignored
// beats. Random phases follow, each under a new round quota. Fill phases push
// both stores past full, drain phases empty them, and mixed phases do both.
// Typed opening rows are checked against the table, all other beats against
// a copy of the queue, stack and round count. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb;
  import fld_pkg::*;

  localparam int WAIT_DEPTH = 64;
  localparam int MISS_DEPTH = 64;
  localparam int ITEM_GOAL = 2000;
  localparam int STALL_LIMIT = 1000;
  localparam int PRINT_CAP = 50;

  localparam result_t R_ACCEPT = '{ST_ACCEPTED, 16'h0000, FROM_WAITING};
  localparam result_t R_EMPTY = '{ST_EMPTY, 16'h0000, FROM_WAITING};

  typedef struct {
    action_t          act;
    logic [VAL_W-1:0] val;
    bit               typed;
    result_t          want;
  } step_row_t;

  // Opening sequence, run with the reset quota of three.
  step_row_t opening [24] = '{
    '{ACT_SERVE,    16'hffff, 1'b1, R_EMPTY},
    '{ACT_IGNORE,   16'hffff, 1'b1, R_ACCEPT},
    '{ACT_ADD_WAIT, 16'h0000, 1'b1, R_ACCEPT},
    '{ACT_ADD_WAIT, 16'hffff, 1'b1, R_ACCEPT},
    '{ACT_ADD_WAIT, 16'h1234, 1'b0, R_ACCEPT},
    '{ACT_ADD_WAIT, 16'h00ff, 1'b0, R_ACCEPT},
    '{ACT_ADD_MISS, 16'haaaa, 1'b1, R_ACCEPT},
    '{ACT_ADD_MISS, 16'h5555, 1'b0, R_ACCEPT},
    '{ACT_SERVE,    16'hffff, 1'b1, '{ST_SERVED, 16'h0000, FROM_WAITING}},
    '{ACT_SERVE,    16'h0000, 1'b1, '{ST_SERVED, 16'hffff, FROM_WAITING}},
    '{ACT_SERVE,    16'h0000, 1'b0, R_ACCEPT},
    '{ACT_SERVE,    16'h0000, 1'b0, R_ACCEPT},
    '{ACT_SERVE,    16'h0000, 1'b0, R_ACCEPT},
    '{ACT_SERVE,    16'h0000, 1'b0, R_ACCEPT},
    '{ACT_SERVE,    16'h0000, 1'b1, R_EMPTY},
    '{ACT_ADD_WAIT, 16'h0001, 1'b0, R_ACCEPT},
    '{ACT_ADD_WAIT, 16'h0002, 1'b0, R_ACCEPT},
    '{ACT_ADD_WAIT, 16'h0003, 1'b0, R_ACCEPT},
    '{ACT_ADD_WAIT, 16'h0004, 1'b0, R_ACCEPT},
    '{ACT_SERVE,    16'h0000, 1'b0, R_ACCEPT},
    '{ACT_SERVE,    16'h0000, 1'b0, R_ACCEPT},
    '{ACT_SERVE,    16'h0000, 1'b0, R_ACCEPT},
    '{ACT_SERVE,    16'h0000, 1'b0, R_ACCEPT},
    '{ACT_IGNORE,   16'h0000, 1'b1, R_ACCEPT}
  };

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  fld_req_if req_ch ();
  fld_rsp_if rsp_ch ();

  fifo_lifo_weighted_dispatcher #(
    .WAIT_DEPTH(WAIT_DEPTH),
    .MISS_DEPTH(MISS_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // Behavioral copy of the dispatcher state.
  logic [VAL_W-1:0] waiting_line[$];
  logic [VAL_W-1:0] missed_pile[$];
  int unsigned      round_count;
  logic [CFG_W-1:0] quota_now;

  result_t pending_results[$];
  int      errors;
  int      stall_cycles;
  bit      sender_gaps_on;
  bit      sink_stalls_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report(string msg);
    if (errors < PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Applies one beat to the state copy and returns the response it causes.
  function automatic result_t dispatch_next(action_t act, logic [VAL_W-1:0] val);
    result_t r;
    r = R_ACCEPT;
    case (act)
      ACT_ADD_WAIT: begin
        if (waiting_line.size() >= WAIT_DEPTH) r.status = ST_FULL;
        else waiting_line.push_back(val);
      end
      ACT_ADD_MISS: begin
        if (missed_pile.size() >= MISS_DEPTH) r.status = ST_FULL;
        else missed_pile.push_back(val);
      end
      ACT_SERVE: begin
        if (waiting_line.size() == 0 && missed_pile.size() == 0) begin
          r.status = ST_EMPTY;
          round_count = 0;
        end else if (waiting_line.size() != 0 && round_count < quota_now) begin
          r.status = ST_SERVED;
          r.served_value = waiting_line.pop_front();
          round_count++;
        end else if (missed_pile.size() != 0) begin
          r.status = ST_SERVED;
          r.served_value = missed_pile.pop_back();
          r.served_from = FROM_MISSED;
          round_count = 0;
        end else begin
          // Quota used up with nothing missed: this serve opens a new round.
          r.status = ST_SERVED;
          r.served_value = waiting_line.pop_front();
          round_count = 1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_beat(action_t act, logic [VAL_W-1:0] val, bit typed,
                           result_t want);
    int      gap;
    result_t pred;
    gap = sender_gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= act;
    req_ch.entry_value <= val;
    do @(posedge clk); while (!req_ch.ready);
    pred = dispatch_next(act, val);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic load_quota(logic [CFG_W-1:0] q);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_we <= 1'b0;
    quota_now = q;
  endtask

  // Percentages pick the action; whatever is left over becomes an ignored beat.
  task automatic random_beats(int count, int pct_wait, int pct_miss, int pct_serve,
                              ref int sent);
    int               pick;
    action_t          act;
    logic [VAL_W-1:0] val;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < pct_wait) act = ACT_ADD_WAIT;
      else if (pick < pct_wait + pct_miss) act = ACT_ADD_MISS;
      else if (pick < pct_wait + pct_miss + pct_serve) act = ACT_SERVE;
      else act = ACT_IGNORE;
      case ($urandom_range(0, 7))
        0: val = '0;
        1: val = '1;
        default: val = VAL_W'($urandom);
      endcase
      send_beat(act, val, 1'b0, R_ACCEPT);
      if (act != ACT_IGNORE) sent++;
    end
  endtask

  // Response side: random back-pressure and the check of every beat.
  initial begin : response_check
    int      stall;
    result_t want;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = sink_stalls_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected beat status %0d value %h",
                         rsp_ch.status, rsp_ch.served_value));
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status)
          report($sformatf("status got %0d expected %0d", rsp_ch.status, want.status));
        if (rsp_ch.served_value !== want.served_value)
          report($sformatf("served_value got %h expected %h",
                           rsp_ch.served_value, want.served_value));
        if (rsp_ch.served_from !== want.served_from)
          report($sformatf("served_from got %0d expected %0d",
                           rsp_ch.served_from, want.served_from));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("fifo_lifo_weighted_dispatcher verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int               sent;
    int               phase;
    logic [CFG_W-1:0] fixed_quotas [4];
    errors = 0;
    sent = 0;
    round_count = 0;
    quota_now = WAITING_PER_ROUND_RST;
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    fixed_quotas = '{4'd15, 4'd0, 4'd1, 4'd15};
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.action <= ACT_ADD_WAIT;
    req_ch.entry_value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i])
      send_beat(opening[i].act, opening[i].val, opening[i].typed, opening[i].want);

    // Each phase starts from an idle block with a fresh quota, so a quota
    // lowered below the running round count is exercised along the way.
    phase = 0;
    while (sent < ITEM_GOAL) begin
      load_quota(phase < 4 ? fixed_quotas[phase] : CFG_W'($urandom_range(0, 15)));
      sender_gaps_on = $urandom_range(0, 3) != 0;
      sink_stalls_on = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 3))
        0: random_beats(150, 48, 48, 2, sent);
        1: random_beats(120, 15, 10, 73, sent);
        default: random_beats(120, 35, 20, 40, sent);
      endcase
      phase++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report($sformatf("%0d beats never arrived", pending_results.size()));
    if (errors == 0) begin
      $display("fifo_lifo_weighted_dispatcher verification clean");
    end else begin
      $display("fifo_lifo_weighted_dispatcher verification failed");
    end
    $finish;
  end

endmodule

/* fifo_lifo_weighted_dispatcher.f */
src/fld_pkg.sv
src/fld_req_if.sv
src/fld_rsp_if.sv
src/fld_cell.sv
src/fld_chain.sv
src/fifo_lifo_weighted_dispatcher.sv
bench/tb.sv
